// File: rtl/asp_b92_pkg.sv
// Package for the AS path de-duplicating base-92 encoder.
// Holds widths, radix constants and the digit-to-character mapping.
// Used by the interfaces, the encoder top level and its checker.
package asp_b92_pkg;

	localparam int ASN_W          = 32;   // input AS number width
	localparam int VAL_W          = 27;   // stored AS number / max_asn width
	localparam int CHAR_W         = 7;    // ASCII code width
	localparam int DIGITS_PER_ASN = 4;
	localparam int CNT_W          = $clog2(DIGITS_PER_ASN + 1);

	localparam int RADIX       = 92;
	localparam int CHAR_BASE   = 33;
	localparam int COLON_DIGIT = 25;

	localparam logic [VAL_W-1:0] MAX_ASN_RESET = VAL_W'(1000000);
	localparam logic [ASN_W-1:0] DIGIT_CAPACITY = ASN_W'(RADIX ** DIGITS_PER_ASN);

	// Division by 92 = (v >> 2) / 23, done as a multiply by a rounded-up reciprocal.
	localparam int QIN_W      = VAL_W - 2;           // width of v >> 2
	localparam int RECIP_SH   = QIN_W + 5;           // 5 = ceil(log2(23))
	localparam int RECIP_W    = QIN_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_23 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd22) / 64'd23);
	localparam int PROD_W     = QIN_W + RECIP_W;
	localparam int QUOT_W     = PROD_W - RECIP_SH;

	localparam logic [CHAR_W-1:0] CHAR_ILLEGAL = CHAR_W'(58);   // ':' never appears
	localparam logic [CHAR_W-1:0] CHAR_LOW     = CHAR_W'(CHAR_BASE);
	localparam logic [CHAR_W-1:0] CHAR_HIGH    = CHAR_W'(CHAR_BASE + RADIX);

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [ASN_W-1:0]  asn_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Map one base-92 digit onto its character, skipping ':'.
	function automatic char_t digit_char(input char_t d);
		char_t c;
		if (d < CHAR_W'(COLON_DIGIT)) begin
			c = d + CHAR_W'(CHAR_BASE);
		end else begin
			c = d + CHAR_W'(CHAR_BASE + 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/asp_b92_in_if.sv
// Input channel of the base-92 encoder: one AS number per transaction.
// Depends on asp_b92_pkg for the field widths.
interface asp_b92_in_if import asp_b92_pkg::*; ();
	logic valid;
	logic ready;
	asn_t as_number;
	logic path_start;
	logic path_end;

	modport source (output valid, output as_number, output path_start, output path_end,
		input ready);
	modport sink (input valid, input as_number, input path_start, input path_end,
		output ready);
endinterface

// File: rtl/asp_b92_out_if.sv
// Output channel of the base-92 encoder: one character or end marker per transaction.
// Depends on asp_b92_pkg for the field widths.
interface asp_b92_out_if import asp_b92_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t out_char;
	logic  char_valid;
	logic  path_rejected;
	logic  end_of_path;

	modport source (output valid, output out_char, output char_valid, output path_rejected,
		output end_of_path, input ready);
	modport sink (input valid, input out_char, input char_valid, input path_rejected,
		input end_of_path, output ready);
endinterface

// File: rtl/as_path_dedup_base92_encoder_unit.sv
// Top level of the AS path de-duplicating base-92 encoder.
// Depends on asp_b92_pkg, asp_b92_in_if and asp_b92_out_if.
//
//   channel   dir  carries                                          transaction when
//   items     in   as_number[31:0], path_start, path_end            valid && ready
//   results   out  out_char[6:0], char_valid, path_rejected,        valid && ready
//                  end_of_path
//   cfg       in   cfg_wdata[26:0] -> max_asn                       cfg_we
//
// A kept AS number gives 4 characters, one per cycle through the result register when
// not stalled; a dropped number with end mark gives a bare end marker, one without
// gives nothing. The digit unit does one divide-by-92 per cycle when not stalled. An item
// passes the input register, the digit register and the result register to its first
// result. Reset clears all valids, the path state and sets max_asn to 1000000. A stalled
// result holds; the input register still fills behind it.
module as_path_dedup_base92_encoder_unit import asp_b92_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  val_t          cfg_wdata,
	asp_b92_in_if.sink    items,
	asp_b92_out_if.source results
);

	// Configuration
	val_t max_asn_q;

	// Input register stage
	logic valid_s1;
	asn_t asn_s1;
	logic start_s1;
	logic end_s1;

	// Path state
	val_t prev_q;
	logic rej_q;

	// Digit unit: remaining digits of the kept number, or a pending bare marker
	val_t v_q;
	cnt_t left_q;
	logic marker_q;
	logic end_q;
	logic rej_w_q;

	// Result register
	logic  res_valid_q;
	char_t char_q;
	logic  cv_q;
	logic  prj_q;
	logic  eop_q;

	// Handshake and flow
	logic out_free;
	logic busy;
	logic emit;
	logic last;
	logic work_free;
	logic adv;
	logic take;

	// Path decision
	val_t prev_eff;
	logic rej_eff;
	logic bad;
	logic keep;
	logic rej_new;
	val_t prev_new;

	// Digit extraction
	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quot;
	val_t              quot_x92;
	val_t              rem_full;
	char_t             digit;

	// Drive the output register whenever it is empty or being drained.
	assign out_free  = !res_valid_q || results.ready;
	assign busy      = (left_q != '0) || marker_q;
	assign emit      = busy && out_free;
	assign last      = (left_q == cnt_t'(1)) || ((left_q == '0) && marker_q);
	assign work_free = !busy || (emit && last);
	assign adv       = valid_s1 && work_free;
	assign items.ready = !valid_s1 || adv;
	assign take      = items.valid && items.ready;

	// Examine the item in the input register against the path state.
	// A start mark clears the state before the item is looked at.
	always_comb begin
		prev_eff = start_s1 ? '0 : prev_q;
		rej_eff  = start_s1 ? 1'b0 : rej_q;
		bad      = (asn_s1 > {{(ASN_W - VAL_W){1'b0}}, max_asn_q}) ||
		           (asn_s1 >= DIGIT_CAPACITY);
		keep     = !rej_eff && !bad && (asn_s1 != {{(ASN_W - VAL_W){1'b0}}, prev_eff});
		rej_new  = rej_eff || bad;
		prev_new = keep ? asn_s1[VAL_W-1:0] : prev_eff;
	end

	// One base-92 digit a cycle when not stalled: quotient by reciprocal, remainder by subtract.
	always_comb begin
		prod     = PROD_W'(v_q[VAL_W-1:2]) * PROD_W'(RECIP_23);
		quot     = prod[PROD_W-1:RECIP_SH];
		quot_x92 = VAL_W'(quot) * VAL_W'(RADIX);
		rem_full = v_q - quot_x92;
		digit    = rem_full[CHAR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_asn_q <= MAX_ASN_RESET;
		end else if (cfg_we) begin
			max_asn_q <= cfg_wdata;
		end
	end

	// Input register: load on every transaction, drop valid once advanced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			asn_s1   <= items.as_number;
			start_s1 <= items.path_start;
			end_s1   <= items.path_end;
		end
	end

	// Path state: advance with each item; an end mark starts a fresh path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			rej_q  <= 1'b0;
		end else if (adv) begin
			if (end_s1) begin
				prev_q <= '0;
				rej_q  <= 1'b0;
			end else begin
				prev_q <= prev_new;
				rej_q  <= rej_new;
			end
		end
	end

	// Digit unit control: a new item overrides the last emission of the previous one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			marker_q <= 1'b0;
		end else if (adv) begin
			left_q   <= keep ? cnt_t'(DIGITS_PER_ASN) : '0;
			marker_q <= end_s1 && !keep;
		end else if (emit) begin
			if (left_q != '0) begin
				left_q <= left_q - cnt_t'(1);
			end else begin
				marker_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_q     <= asn_s1[VAL_W-1:0];
			end_q   <= end_s1;
			rej_w_q <= rej_new;
		end else if (emit && (left_q != '0)) begin
			v_q <= VAL_W'(quot);
		end
	end

	// Result register: hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (left_q != '0) begin
				char_q <= digit_char(digit);
				cv_q   <= 1'b1;
				prj_q  <= rej_w_q;
				eop_q  <= end_q && (left_q == cnt_t'(1));
			end else begin
				char_q <= '0;
				cv_q   <= 1'b0;
				prj_q  <= rej_w_q;
				eop_q  <= 1'b1;
			end
		end
	end

	assign results.valid         = res_valid_q;
	assign results.out_char      = char_q;
	assign results.char_valid    = cv_q;
	assign results.path_rejected = prj_q;
	assign results.end_of_path   = eop_q;

endmodule

// File: rtl/asp_b92_chk.sv
// Port-level checker for the base-92 encoder, bound to the top level.
// Depends on asp_b92_pkg and on as_path_dedup_base92_encoder_unit.
module asp_b92_chk import asp_b92_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  res_valid,
	input logic  res_ready,
	input char_t out_char,
	input logic  char_valid,
	input logic  path_rejected,
	input logic  end_of_path
);

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_char) &&
		$stable(char_valid) && $stable(path_rejected) && $stable(end_of_path))
		else $error("stalled result changed");

	// Characters stay in the base-92 alphabet and never show ':'.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && char_valid |-> out_char >= CHAR_LOW && out_char <= CHAR_HIGH &&
		out_char != CHAR_ILLEGAL)
		else $error("character outside alphabet");

	// A bare marker always closes a path and carries no character.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !char_valid |-> end_of_path && out_char == '0)
		else $error("bare marker malformed");

	// Characters are only sent for paths not rejected.
	a_norej: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && char_valid |-> !path_rejected)
		else $error("character on rejected path");

endmodule

bind as_path_dedup_base92_encoder_unit asp_b92_chk u_asp_b92_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.out_char      (results.out_char),
	.char_valid    (results.char_valid),
	.path_rejected (results.path_rejected),
	.end_of_path   (results.end_of_path)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the AS path de-duplicating base-92 encoder.
// Depends on asp_b92_pkg, asp_b92_in_if, asp_b92_out_if and as_path_dedup_base92_encoder_unit.
module testbench;
	import asp_b92_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 10;
	localparam int DRAIN_PAD     = 12;     // pad that lets the pipeline empty after the owed characters
	localparam int QUIET_LIMIT   = 2000;   // cycles with no transaction on either channel
	localparam int ITEM_TARGET   = 410;
	localparam int PHASE_ITEMS   = 40;
	localparam int MAX_PRINTED   = 40;
	localparam asn_t TOP_ASN      = DIGIT_CAPACITY - 1;   // largest number that fits 4 digits
	localparam val_t VAL_ALL_ONES = '1;

	// One character (or bare end marker) on the result channel.
	typedef struct packed {
		char_t ch;
		logic  has_char;
		logic  rejected;
		logic  eop;
	} path_char_t;

	// Tracks the path state and the characters still owed by the encoder.
	class path_char_tracker;
		val_t       max_asn;
		val_t       last_kept;
		bit         path_rejected;
		path_char_t pending_chars[$];
		int         errors;

		function new();
			max_asn       = MAX_ASN_RESET;
			last_kept     = '0;
			path_rejected = 1'b0;
			errors        = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Queue the characters one accepted AS number causes; return how many.
		function int take_asn(asn_t asn, logic first, logic last);
			path_char_t chars[DIGITS_PER_ASN];
			asn_t       rest;
			int         digit;
			int         n;
			int         i;
			n    = 0;
			rest = asn;
			if (first) begin
				last_kept     = '0;
				path_rejected = 1'b0;
			end
			if (!path_rejected) begin
				if (asn > asn_t'(max_asn) || asn >= DIGIT_CAPACITY) begin
					path_rejected = 1'b1;
				end else if (asn != asn_t'(last_kept)) begin
					last_kept = val_t'(asn);
					for (i = 0; i < DIGITS_PER_ASN; i++) begin
						digit = int'(rest % RADIX);
						rest  = rest / RADIX;
						chars[n].ch       = (digit < COLON_DIGIT) ? char_t'(CHAR_BASE + digit)
							: char_t'(CHAR_BASE + 1 + digit);
						chars[n].has_char = 1'b1;
						chars[n].eop      = 1'b0;
						n++;
					end
				end
			end
			if (last) begin
				if (n == 0) begin
					chars[0].ch       = '0;
					chars[0].has_char = 1'b0;
					chars[0].eop      = 1'b1;
					n = 1;
				end else begin
					chars[n-1].eop = 1'b1;
				end
			end
			for (i = 0; i < n; i++) begin
				chars[i].rejected = path_rejected;
				pending_chars.insert(pending_chars.size(), chars[i]);
			end
			if (last) begin
				last_kept     = '0;
				path_rejected = 1'b0;
			end
			return n;
		endfunction

		// Compare one accepted result with the oldest owed character.
		task match_char(path_char_t got);
			path_char_t want;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected result char=%0d valid=%b rejected=%b end=%b",
					got.ch, got.has_char, got.rejected, got.eop));
			end else begin
				want = pending_chars.pop_front();
				if (got.ch !== want.ch || got.has_char !== want.has_char ||
					got.rejected !== want.rejected || got.eop !== want.eop)
					report($sformatf("got/want char %0d/%0d valid %b/%b rejected %b/%b end %b/%b",
						got.ch, want.ch, got.has_char, want.has_char,
						got.rejected, want.rejected, got.eop, want.eop));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	val_t cfg_wdata;

	asp_b92_in_if  items_if();
	asp_b92_out_if results_if();

	as_path_dedup_base92_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (items_if),
		.results  (results_if)
	);

	path_char_tracker tracker = new();

	int sent_items = 0;         // accepted AS numbers
	bit sender_steady = 1'b0;   // when set, the sender never inserts gaps

	always #HALF_PERIOD clk = ~clk;

	// Offer one AS number and hold it until the encoder takes it. Every call
	// starts and ends right after a rising edge, so valid gets at most one
	// assignment per time step: lowered only when a gap is drawn.
	task send_asn(asn_t asn, logic first, logic last);
		int gap;
		int n;
		gap = sender_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.as_number  <= asn;
		items_if.path_start <= first;
		items_if.path_end   <= last;
		// Sample ready as it stood before the edge: the transaction happens here.
		do @(posedge clk); while (!items_if.ready);
		n = tracker.take_asn(asn, first, last);
		sent_items++;
	endtask

	// Drop valid, wait for every owed character, then let the pipeline empty out:
	// a dropped number leaves no character behind but may still be in flight.
	task settle();
		items_if.valid <= 1'b0;
		while (tracker.pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Write max_asn while the encoder is idle; the predictor follows at the same edge.
	task write_max_asn(val_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.max_asn = value;
	endtask

	// Draw the next AS number of a path: favor repeats, zeros and the bounds.
	function asn_t next_asn(asn_t prev);
		asn_t lim;
		int   r;
		lim = asn_t'(tracker.max_asn);
		if (lim > TOP_ASN)
			lim = TOP_ASN;
		r = $urandom_range(0, 99);
		if (r < 25)
			return prev;
		else if (r < 30)
			return '0;
		else if (r < 33)
			return asn_t'(tracker.max_asn) + 1;
		else if (r < 38)
			return lim;
		else if (r < 41)
			return $urandom();
		else
			return $urandom_range(0, lim);
	endfunction

	// Mostly well-formed paths with random content; the rest is loose items with
	// random marks and paths that lose their start or end mark.
	task run_phase(int quota);
		asn_t pick;
		int   stop_at;
		int   len;
		int   k;
		bit   no_start;
		bit   no_end;
		pick    = '0;
		stop_at = sent_items + quota;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 6) == 0) begin
				send_asn($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				len      = $urandom_range(1, 8);
				no_start = ($urandom_range(0, 9) == 0);
				no_end   = ($urandom_range(0, 9) == 0);
				for (k = 0; k < len; k++) begin
					pick = next_asn(pick);
					send_asn(pick, k == 0 && !no_start, k == len - 1 && !no_end);
				end
			end
		end
	endtask

	// Result side: stall at random, in stretches with and without stalls,
	// and check every accepted transaction.
	initial begin
		int         stall;
		int         run;
		bit         steady;
		path_char_t got;
		run    = 0;
		steady = 1'b0;
		results_if.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (run == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				run    = $urandom_range(8, 40);
			end
			run--;
			stall = steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
			got.ch       = results_if.out_char;
			got.has_char = results_if.char_valid;
			got.rejected = results_if.path_rejected;
			got.eop      = results_if.end_of_path;
			tracker.match_char(got);
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		// Hold every input at a known value through reset.
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		items_if.valid      <= 1'b0;
		items_if.as_number  <= '0;
		items_if.path_start <= 1'b0;
		items_if.path_end   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset limit of 1000000.
		send_asn('0, 1'b1, 1'b0);                       // leading zero is dropped
		send_asn(32'd1, 1'b0, 1'b0);                    // high zero digits come out as '!'
		send_asn(32'd1, 1'b0, 1'b0);                    // repeat is dropped
		send_asn(32'd24, 1'b0, 1'b0);                   // last digit below the colon gap
		send_asn(32'd25, 1'b0, 1'b0);                   // first digit that skips ':'
		send_asn(32'd91, 1'b0, 1'b0);                   // top digit
		send_asn(32'd92, 1'b0, 1'b0);                   // carry into the second digit
		send_asn(asn_t'(MAX_ASN_RESET), 1'b0, 1'b0);    // exactly at the limit
		send_asn(asn_t'(MAX_ASN_RESET), 1'b0, 1'b1);    // dropped with end mark: bare marker
		send_asn(32'd5, 1'b0, 1'b1);                    // fresh path without a start mark
		send_asn(32'd10, 1'b1, 1'b0);
		send_asn(32'd11, 1'b0, 1'b0);
		send_asn(32'd11, 1'b1, 1'b1);                   // start mid-path clears the repeat
		send_asn(32'd7, 1'b1, 1'b0);
		send_asn(32'd1000001, 1'b0, 1'b0);              // one above the limit rejects the path
		send_asn(32'd8, 1'b0, 1'b0);                    // silent once rejected
		send_asn(32'd9, 1'b0, 1'b1);                    // end marker carries the reject flag
		send_asn('1, 1'b1, 1'b1);
		settle();

		// Limit of zero: only zero passes, and zero is always a repeat.
		write_max_asn('0);
		send_asn('0, 1'b1, 1'b1);
		send_asn(32'd1, 1'b1, 1'b1);
		settle();

		// Limit at the digit capacity.
		write_max_asn(val_t'(TOP_ASN));
		send_asn(TOP_ASN, 1'b1, 1'b0);
		send_asn(TOP_ASN + 1, 1'b0, 1'b1);
		settle();

		// Limit beyond the digit capacity: the capacity still rejects.
		write_max_asn(VAL_ALL_ONES);
		send_asn(TOP_ASN + 1, 1'b1, 1'b1);
		send_asn(asn_t'(VAL_ALL_ONES), 1'b1, 1'b1);
		settle();

		// Random phases, each under a fresh limit.
		while (sent_items < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: write_max_asn(MAX_ASN_RESET);
				1: write_max_asn('0);
				2: write_max_asn(val_t'(TOP_ASN));
				3: write_max_asn(VAL_ALL_ONES);
				4: write_max_asn(val_t'($urandom_range(1, 300)));
				default: write_max_asn(val_t'($urandom()));
			endcase
			sender_steady = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_ITEMS);
			settle();
		end

		// settle() waited out the owed characters and the pipeline latency;
		// anything extra has been flagged as unexpected by now.
		if (tracker.pending_chars.size() != 0)
			tracker.report($sformatf("%0d characters never arrived",
				tracker.pending_chars.size()));
		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
